>>> hw/rtl/sprite_quad_vertex_gen_unit_macros.svh
// Assertion macros for the sprite quad vertex generator RTL
`ifndef SPRITE_QUAD_VERTEX_GEN_UNIT_MACROS_SVH
`define SPRITE_QUAD_VERTEX_GEN_UNIT_MACROS_SVH

// Plain property check on the module clock, off while in reset
`define SQV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication on the module clock, off while in reset
`define SQV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sqv_pkg.sv
// Shared types, constants and helpers of the sprite quad vertex generator
`default_nettype none
package sqv_pkg;

	localparam int TEX_SLOTS_DEF  = 32;
	localparam int TRIG_BITS_DEF  = 10;

	localparam int IN_W   = 328;
	localparam int OUT_W  = 168;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// register indexes of the configuration port
	localparam logic [CFG_AW-1:0] REG_BASE_A  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_BASE_B  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_BASE_C  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BASE_D  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_BASE_TX = 3'd4;
	localparam logic [CFG_AW-1:0] REG_BASE_TY = 3'd5;
	localparam logic [CFG_AW-1:0] REG_SHEET_W = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SHEET_H = 3'd7;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	// divider geometry: 32 quotient bits, four per stage
	localparam int DIV_NW     = 32;
	localparam int DIV_BPS    = 4;
	localparam int DIV_STAGES = DIV_NW / DIV_BPS;

	localparam int QUEUE_DEPTH = 4;

	localparam int WIDE_W = 68;
	localparam logic signed [WIDE_W-1:0] SAT_HI = 68'sh7FFFFFFF;
	localparam logic signed [WIDE_W-1:0] SAT_LO = 68'shF_FFFF_FFFF_8000_0000;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
	} affine_t;

	// one classified sprite, handed from the front part to the back part
	typedef struct packed {
		logic signed [17:0] sn;
		logic signed [17:0] cs;
		logic [30:0]        w;
		logic [30:0]        h;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] fu;
		logic signed [31:0] fv;
		logic signed [31:0] tu_r;
		logic signed [31:0] tv_f;
		logic [31:0]        tint;
		logic [4:0]         slot;
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (v > SAT_HI) begin
			return 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sqv_div.sv
// Pipelined restoring divider, BPS quotient bits per stage
`default_nettype none
module sqv_div #(
	parameter int NW  = 32,
	parameter int DW  = 16,
	parameter int BPS = 4
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo
);
	localparam int NS = NW / BPS;

	logic [NW-1:0] num_q [NS];
	logic [NW-1:0] quo_q [NS];
	logic [DW-1:0] rem_q [NS];
	logic [DW-1:0] den_q [NS];

	for (genvar s = 0; s < NS; s++) begin : g_st
		logic [NW-1:0] num_in, quo_in, num_nx, quo_nx;
		logic [DW-1:0] rem_in, den_in, rem_nx;

		if (s == 0) begin : g_head
			assign num_in = num;
			assign quo_in = '0;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_body
			assign num_in = num_q[s-1];
			assign quo_in = quo_q[s-1];
			assign rem_in = rem_q[s-1];
			assign den_in = den_q[s-1];
		end

		// shift in numerator bits and subtract where the divisor fits
		always_comb begin
			logic [DW:0] t;
			rem_nx = rem_in;
			num_nx = num_in;
			quo_nx = quo_in;
			for (int b = 0; b < BPS; b++) begin
				t = {rem_nx, num_nx[NW-1]};
				num_nx = {num_nx[NW-2:0], 1'b0};
				if (t >= {1'b0, den_in}) begin
					t = t - {1'b0, den_in};
					quo_nx = {quo_nx[NW-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[NW-2:0], 1'b0};
				end
				rem_nx = t[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[s] <= num_nx;
				quo_q[s] <= quo_nx;
				rem_q[s] <= rem_nx;
				den_q[s] <= den_in;
			end
		end
	end

	assign quo = quo_q[NS-1];
endmodule
`default_nettype wire

>>> hw/rtl/sqv_front.sv
// Front part: accept sprites, reduce the angle, look up sin/cos, divide UV sizes
`default_nettype none
module sqv_front #(
	parameter int TEX_SLOTS = 32,
	parameter int TRIG_BITS = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [sqv_pkg::IN_W-1:0] in_data,
	input  wire logic [15:0]              sheet_w,
	input  wire logic [15:0]              sheet_h,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output sqv_pkg::job_t                 out_job
);
	import sqv_pkg::*;

	localparam int FD   = DIV_STAGES;
	localparam int QS   = 2 ** (TRIG_BITS - 2);
	localparam int XW   = TRIG_BITS + 6;
	localparam int KSH  = TRIG_BITS + 6;
	localparam int RCW  = KSH - 4;
	localparam int P3W  = XW + RCW;
	localparam int NW2  = 25 + TRIG_BITS + 1;
	localparam logic [RCW-1:0] RECIP = RCW'((64'd1 << KSH) / 45);
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DEN [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};
	localparam logic [8:0] SLOT_LIM = 9'(TEX_SLOTS);
	localparam logic [4:0] SLOT_MAX = 5'((TEX_SLOTS - 1) % 32);

	typedef logic [16:0] rom_t [0:QS];

	// quarter-wave sine table in Q1.16, built at elaboration
	function automatic rom_t build_rom();
		rom_t t;
		longint unsigned x, x2, term, val;
		longint sum;
		for (int k = 0; k <= QS; k++) begin
			x = (HALF_PI_Q30 * longint'(k) + longint'(QS / 2)) >> (TRIG_BITS - 2);
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = (term * x2) >> 30;
				term = term / TAYLOR_DEN[n];
				if (n[0]) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			val = (longint'(sum) + 8192) >> 14;
			if (val > 65536) begin
				val = 65536;
			end
			t[k] = val[16:0];
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	function automatic logic signed [17:0] sine_at(input logic [TRIG_BITS-1:0] i);
		logic [TRIG_BITS-3:0] j;
		logic [TRIG_BITS-2:0] a;
		logic [16:0]          m;
		j = i[TRIG_BITS-3:0];
		a = i[TRIG_BITS-2] ? (TRIG_BITS-1)'(QS) - {1'b0, j} : {1'b0, j};
		m = SINE_ROM[a];
		return i[TRIG_BITS-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	typedef struct packed {
		logic [30:0]        w;
		logic [30:0]        h;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] fu;
		logic signed [31:0] fv;
		logic [31:0]        tint;
		logic [4:0]         slot;
	} carry_t;

	logic          en;
	logic [FD:1]   v_q;
	carry_t        carry_in;
	carry_t        carry_q [1:FD];
	logic [31:0]   ang;
	logic [4:0]    slot_in;

	// stage registers of the angle path
	logic [13:0]          hi_off_s1;
	logic [18:0]          lo_s1;
	logic [24:0]          p1_s1;
	logic [XW-1:0]        x_s2, x_s3;
	logic [P3W-1:0]       p3_s3;
	logic [TRIG_BITS-1:0] idx_s4;
	logic signed [17:0]   sn_q [5:FD];
	logic signed [17:0]   cs_q [5:FD];

	logic [13:0]          hi_off_d;
	logic [8:0]           q1;
	logic [13:0]          rem1;
	logic [5:0]           r45;
	logic [NW2-1:0]       n2;
	logic [TRIG_BITS+1:0] q0;
	logic [XW-1:0]        rem3;
	logic [TRIG_BITS+1:0] qr;

	logic [15:0] sw, sh;
	logic [31:0] num_u, num_v, uoff, voff;

	// advance the whole front whenever the last stage can leave
	assign en        = !v_q[FD] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[FD];

	// unpack the item and clamp the slot
	assign carry_in.px   = in_data[31:0];
	assign carry_in.py   = in_data[63:32];
	assign carry_in.w    = in_data[94:64];
	assign carry_in.h    = in_data[125:95];
	assign ang           = in_data[157:126];
	assign carry_in.sx   = in_data[189:158];
	assign carry_in.sy   = in_data[221:190];
	assign carry_in.fu   = in_data[253:222];
	assign carry_in.fv   = in_data[285:254];
	assign carry_in.tint = in_data[317:286];
	assign slot_in       = in_data[322:318];
	assign carry_in.slot = ({4'b0, slot_in} >= SLOT_LIM) ? SLOT_MAX : slot_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[FD-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_q[1] <= carry_in;
			for (int s = 2; s <= FD; s++) begin
				carry_q[s] <= carry_q[s-1];
			end
		end
	end

	// stage 1: fold the whole-degree part into a positive value, scale by 1/45
	assign hi_off_d = {ang[31], ang[31:19]} + 14'd4140;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_off_s1 <= hi_off_d;
			lo_s1     <= ang[18:0];
			p1_s1     <= 25'(hi_off_d) * 25'd1456;
		end
	end

	// stage 2: finish the modulo and form the table position scaled by the step count
	always_comb begin
		q1   = p1_s1[24:16];
		rem1 = hi_off_s1 - 14'(q1) * 14'd45;
		r45  = (rem1 >= 14'd45) ? 6'(rem1 - 14'd45) : 6'(rem1);
		n2   = {1'b0, r45, lo_s1, {TRIG_BITS{1'b0}}} + NW2'(45 * (2 ** 18));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= XW'(n2 >> 19);
		end
	end

	// stage 3: multiply by the reciprocal of 45
	always_ff @(posedge clk) begin
		if (en) begin
			p3_s3 <= P3W'(x_s2) * P3W'(RECIP);
			x_s3  <= x_s2;
		end
	end

	// stage 4: correct the quotient into the table index
	always_comb begin
		q0   = p3_s3[P3W-1:KSH];
		rem3 = x_s3 - XW'(q0) * XW'(45);
		qr   = (rem3 >= XW'(45)) ? q0 + 1'b1 : q0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s4 <= qr[TRIG_BITS-1:0];
		end
	end

	// stage 5: table lookups, then hold until the quotients arrive
	always_ff @(posedge clk) begin
		if (en) begin
			sn_q[5] <= sine_at(idx_s4);
			cs_q[5] <= sine_at(idx_s4 + TRIG_BITS'(QS));
			for (int s = 6; s <= FD; s++) begin
				sn_q[s] <= sn_q[s-1];
				cs_q[s] <= cs_q[s-1];
			end
		end
	end

	// UV offsets: rounded size over sheet size, zero sheet acts as one
	assign sw    = (sheet_w == 16'd0) ? 16'd1 : sheet_w;
	assign sh    = (sheet_h == 16'd0) ? 16'd1 : sheet_h;
	assign num_u = {1'b0, carry_in.w} + {17'b0, sw[15:1]};
	assign num_v = {1'b0, carry_in.h} + {17'b0, sh[15:1]};

	sqv_div #(.NW(DIV_NW), .DW(16), .BPS(DIV_BPS)) u_div_u (
		.clk (clk),
		.en  (en),
		.num (num_u),
		.den (sw),
		.quo (uoff)
	);

	sqv_div #(.NW(DIV_NW), .DW(16), .BPS(DIV_BPS)) u_div_v (
		.clk (clk),
		.en  (en),
		.num (num_v),
		.den (sh),
		.quo (voff)
	);

	// assemble the job for the queue
	always_comb begin
		out_job.sn   = sn_q[FD];
		out_job.cs   = cs_q[FD];
		out_job.w    = carry_q[FD].w;
		out_job.h    = carry_q[FD].h;
		out_job.px   = carry_q[FD].px;
		out_job.py   = carry_q[FD].py;
		out_job.sx   = carry_q[FD].sx;
		out_job.sy   = carry_q[FD].sy;
		out_job.fu   = carry_q[FD].fu;
		out_job.fv   = carry_q[FD].fv;
		out_job.tu_r = sat32(WIDE_W'(carry_q[FD].fu) + WIDE_W'(uoff));
		out_job.tv_f = sat32(WIDE_W'(carry_q[FD].fv) - WIDE_W'(voff));
		out_job.tint = carry_q[FD].tint;
		out_job.slot = carry_q[FD].slot;
	end
endmodule
`default_nettype wire

>>> hw/rtl/sqv_queue.sv
// Short job queue between the front and back parts
`default_nettype none
module sqv_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sqv_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               valid,
	output sqv_pkg::job_t      head
);
	import sqv_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	// store on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/sqv_back.sv
// Back part: four transformed corners per job, one per cycle while not stalled
`default_nettype none
module sqv_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire sqv_pkg::job_t    q_job,
	output logic                  q_pop,
	input  wire sqv_pkg::affine_t base,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic signed [31:0]    vert_x,
	output logic signed [31:0]    vert_y,
	output logic signed [31:0]    tex_u,
	output logic signed [31:0]    tex_v,
	output logic [31:0]           vert_tint,
	output logic [4:0]            vert_slot,
	output logic [1:0]            corner,
	output logic                  last_corner
);
	import sqv_pkg::*;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] tu;
		logic signed [31:0] tv;
		logic [31:0]        tint;
		logic [4:0]         slot;
		logic [1:0]         corner;
	} side_t;

	logic        en;
	logic        issue;
	logic [6:1]  v_q;
	logic [1:0]  cnt_q;
	side_t       side_in;
	side_t       side_q [1:6];
	logic        xpos, ypos;
	logic signed [32:0] du, dv;

	logic signed [50:0] cdu_s1, sdv_s1, sdu_s1, cdv_s1;
	logic [30:0]        w_s1, h_s1;
	logic signed [52:0] sum_x, sum_y;
	logic signed [35:0] qx_s2, qy_s2;
	logic signed [67:0] px_s3, py_s3;
	logic signed [67:0] rx, ry;
	logic signed [31:0] wx_s4, wy_s4;
	logic signed [63:0] pa_s5, pb_s5, pc_s5, pd_s5;
	logic signed [67:0] ra, rb, rc, rd;
	logic signed [31:0] vx_s6, vy_s6;

	// move every stage together when the output stage can empty
	assign en        = !v_q[6] || out_ready;
	assign issue     = en && q_valid;
	assign q_pop     = issue && (cnt_q == CORNER_LAST);
	assign out_valid = v_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			cnt_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], q_valid};
			if (q_valid) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// choose corner signs and texture coordinates
	always_comb begin
		xpos = (cnt_q == 2'd1) || (cnt_q == 2'd2);
		ypos = cnt_q[1];
		du   = xpos ? $signed({2'b0, q_job.w}) : -$signed({2'b0, q_job.w});
		dv   = ypos ? $signed({2'b0, q_job.h}) : -$signed({2'b0, q_job.h});
		side_in.px     = q_job.px;
		side_in.py     = q_job.py;
		side_in.sx     = q_job.sx;
		side_in.sy     = q_job.sy;
		side_in.tu     = xpos ? q_job.tu_r : q_job.fu;
		side_in.tv     = ypos ? q_job.tv_f : q_job.fv;
		side_in.tint   = q_job.tint;
		side_in.slot   = q_job.slot;
		side_in.corner = cnt_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[1] <= side_in;
			for (int s = 2; s <= 6; s++) begin
				side_q[s] <= side_q[s-1];
			end
		end
	end

	// stage 1: rotation products on doubled offsets
	always_ff @(posedge clk) begin
		if (en) begin
			cdu_s1 <= q_job.cs * du;
			sdv_s1 <= q_job.sn * dv;
			sdu_s1 <= q_job.sn * du;
			cdv_s1 <= q_job.cs * dv;
			w_s1   <= q_job.w;
			h_s1   <= q_job.h;
		end
	end

	// stage 2: add the centre and halve with rounding
	always_comb begin
		sum_x = 53'(cdu_s1) - 53'(sdv_s1) + 53'({1'b0, w_s1, 16'b0}) + 53'sd65536;
		sum_y = 53'(sdu_s1) + 53'(cdv_s1) + 53'({1'b0, h_s1, 16'b0}) + 53'sd65536;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s2 <= sum_x[52:17];
			qy_s2 <= sum_y[52:17];
		end
	end

	// stage 3: scale
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= side_q[2].sx * qx_s2;
			py_s3 <= side_q[2].sy * qy_s2;
		end
	end

	// stage 4: round, translate, saturate to the world point
	always_comb begin
		rx = (px_s3 + 68'sd32768) >>> 16;
		ry = (py_s3 + 68'sd32768) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s4 <= sat32(rx + WIDE_W'(side_q[3].px));
			wy_s4 <= sat32(ry + WIDE_W'(side_q[3].py));
		end
	end

	// stage 5: base affine products
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s5 <= base.a * wx_s4;
			pb_s5 <= base.b * wy_s4;
			pc_s5 <= base.c * wx_s4;
			pd_s5 <= base.d * wy_s4;
		end
	end

	// stage 6: round each product, sum with the translation, saturate
	always_comb begin
		ra = WIDE_W'((pa_s5 + 64'sd32768) >>> 16);
		rb = WIDE_W'((pb_s5 + 64'sd32768) >>> 16);
		rc = WIDE_W'((pc_s5 + 64'sd32768) >>> 16);
		rd = WIDE_W'((pd_s5 + 64'sd32768) >>> 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s6 <= sat32(ra + rb + WIDE_W'(base.tx));
			vy_s6 <= sat32(rc + rd + WIDE_W'(base.ty));
		end
	end

	assign vert_x      = vx_s6;
	assign vert_y      = vy_s6;
	assign tex_u       = side_q[6].tu;
	assign tex_v       = side_q[6].tv;
	assign vert_tint   = side_q[6].tint;
	assign vert_slot   = side_q[6].slot;
	assign corner      = side_q[6].corner;
	assign last_corner = (side_q[6].corner == CORNER_LAST);

	`include "sprite_quad_vertex_gen_unit_macros.svh"

	`SQV_ASSERT(a_pop_on_last, !q_pop || (q_valid && en && cnt_q == CORNER_LAST), "pop off last corner")
	`SQV_ASSERT_NEXT(a_issue_enters, issue, v_q[1] && side_q[1].corner == $past(cnt_q), "issue lost")
	`SQV_ASSERT_NEXT(a_corner_seq, out_valid && out_ready && !last_corner, !out_valid || corner == $past(corner) + 2'd1, "corner order broken")
endmodule
`default_nettype wire

>>> hw/rtl/sprite_quad_vertex_gen_unit.sv
// A sprite runs through the front, the job queue and the back; its vertices then leave
// one a cycle while m_tready is high, four per sprite; the front (8-stage divider and angle
// pipeline) takes a sprite every cycle unless the queue is full and its last stage waits.
// A four-entry job queue lets the front keep accepting while the back drains vertices.
// Reset (arst_n low) clears all control state and loads the default configuration.
`default_nettype none
module sprite_quad_vertex_gen_unit #(
	parameter int TEX_SLOTS = sqv_pkg::TEX_SLOTS_DEF,
	parameter int TRIG_TABLE_BITS = sqv_pkg::TRIG_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// pos_x, pos_y, size_w, size_h, angle_deg, scale_x, scale_y, frame_u, frame_v, tint, tex_slot
	input  wire logic [sqv_pkg::IN_W-1:0]    s_tdata,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// vert_x, vert_y, tex_u, tex_v, vert_tint, vert_slot
	output logic [sqv_pkg::OUT_W-1:0]        m_tdata,
	// corner
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic                        cfg_we,
	input  wire logic [sqv_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [sqv_pkg::CFG_DW-1:0]  cfg_data
);
	import sqv_pkg::*;

	affine_t     base_q;
	logic [15:0] sheet_w_q, sheet_h_q;

	logic  f_valid, q_full, q_valid, q_pop;
	job_t  f_job, q_head;

	logic signed [31:0] vert_x, vert_y, tex_u, tex_v;
	logic [31:0]        vert_tint;
	logic [4:0]         vert_slot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q.a  <= 32'sd65536;
			base_q.b  <= '0;
			base_q.c  <= '0;
			base_q.d  <= 32'sd65536;
			base_q.tx <= '0;
			base_q.ty <= '0;
			sheet_w_q <= 16'd1;
			sheet_h_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BASE_A:  base_q.a  <= cfg_data;
				REG_BASE_B:  base_q.b  <= cfg_data;
				REG_BASE_C:  base_q.c  <= cfg_data;
				REG_BASE_D:  base_q.d  <= cfg_data;
				REG_BASE_TX: base_q.tx <= cfg_data;
				REG_BASE_TY: base_q.ty <= cfg_data;
				REG_SHEET_W: sheet_w_q <= cfg_data[15:0];
				REG_SHEET_H: sheet_h_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	sqv_front #(.TEX_SLOTS(TEX_SLOTS), .TRIG_BITS(TRIG_TABLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.sheet_w   (sheet_w_q),
		.sheet_h   (sheet_h_q),
		.out_valid (f_valid),
		.out_ready (!q_full),
		.out_job   (f_job)
	);

	sqv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid && !q_full),
		.push_job (f_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	sqv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (q_head),
		.q_pop       (q_pop),
		.base        (base_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.vert_tint   (vert_tint),
		.vert_slot   (vert_slot),
		.corner      (m_tuser),
		.last_corner (m_tlast)
	);

	// pack the vertex, zero padding on top
	assign m_tdata = {3'b0, vert_slot, vert_tint, tex_v, tex_u, vert_y, vert_x};
endmodule
`default_nettype wire
